[rtl/gradient_window_bit_packer_macros.svh]
// Assertion helpers for the gradient window bit packer.
`ifndef GRADIENT_WINDOW_BIT_PACKER_MACROS_SVH
`define GRADIENT_WINDOW_BIT_PACKER_MACROS_SVH

// Checked only while the block is out of reset.
`define GWBP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gwbp check failed");

// Checked at every edge, reset included.
`define GWBP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("gwbp check failed");

`endif

[rtl/gwbp_pkg.sv]
package gwbp_pkg;

	// Bit planes taken from the magnitude byte: bits 4 to 7.
	localparam int unsigned NPLANES = 4;
	localparam int unsigned PLANE_LO = 4;

	// Window geometry: 8 columns by 8 rows.
	localparam int unsigned WIN = 8;
	localparam int unsigned WORD_W = WIN * WIN;
	// Only the low 56 bits of a word survive the shift by one row.
	localparam int unsigned STORE_W = WORD_W - WIN;

	// Position counters.
	localparam int unsigned COL_W = 13;
	localparam int unsigned ROW_W = 4;
	localparam logic [COL_W-1:0] COL_MAX = 13'd8191;
	localparam logic [ROW_W-1:0] ROW_MAX = 4'd15;

	typedef logic [NPLANES-1:0][WIN-1:0] plane_bytes_t;
	typedef logic [NPLANES-1:0][STORE_W-1:0] store_word_t;
	typedef logic [NPLANES-1:0][WORD_W-1:0] plane_words_t;

endpackage

[rtl/gradient_window_bit_packer.sv]
// Gradient window bit packer.
// Input channel (in_valid/in_ready) takes one gradient magnitude byte per
// transaction in raster order, with row_start and frame_start marks. The output
// channel (out_valid/out_ready) returns one transaction per input: four 8x8 bit
// windows of magnitude bits 4 to 7 (newest row in the low byte), window_full
// and too_wide.
// Output valid rises once an input has passed both stages: one stage holds the
// line store read, the second is the output register. The block takes one
// pixel per clock while the receiver does not stall, set by the single read and
// single write port of the line store, which is MAX_WIDTH entries of 4 x 56
// bits.
// A same-column read right behind a write (one-pixel rows) is served from a
// forwarding register, so no bubble is needed.
// When the receiver stalls, the output register holds its transaction and the
// input keeps accepting until the internal stage is also full; then in_ready
// drops. Reset clears the counters, the shift registers and all valid flags.
// The line store is not cleared; the first row of each frame ignores it.
module gradient_window_bit_packer
	import gwbp_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          pixel,
	input  logic                row_start,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WORD_W-1:0]   window_bits4,
	output logic [WORD_W-1:0]   window_bits5,
	output logic [WORD_W-1:0]   window_bits6,
	output logic [WORD_W-1:0]   window_bits7,
	output logic                window_full,
	output logic                too_wide
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_WIDTH);

	// Position and shift state.
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	plane_bytes_t     shift_q, shift_d;

	// Stage 1: line store read in flight.
	logic             valid_s1;
	logic [AW-1:0]    idx_s1;
	logic             first_row_s1;
	logic             too_wide_s1;
	logic             full_s1;
	logic             fwd_s1;
	plane_bytes_t     shift_s1;
	store_word_t      rd_s1;
	store_word_t      fwd_s1_word;

	// Output register.
	logic             out_valid_q;
	plane_words_t     win_q;
	logic             full_q;
	logic             too_wide_q;

	// Line store.
	store_word_t      line_mem [MAX_WIDTH];

	logic             accept;
	logic             adv_s1;
	logic             start;
	logic             wide_d;
	logic [COL_W-1:0] col_m1;
	logic [AW-1:0]    idx_d;
	store_word_t      upper_s1;
	store_word_t      store_s1;
	plane_words_t     word_s1;

	// Handshake: stage 1 moves on when the output register is free or drains.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;
	assign start    = row_start || frame_start;

	// Next position and shift registers for the incoming pixel.
	always_comb begin
		if (frame_start) begin
			row_d = ROW_W'(1);
		end else if (row_start && row_q < ROW_MAX) begin
			row_d = row_q + ROW_W'(1);
		end else begin
			row_d = row_q;
		end
		if (start) begin
			col_d = COL_W'(1);
		end else if (col_q < COL_MAX) begin
			col_d = col_q + COL_W'(1);
		end else begin
			col_d = col_q;
		end
		wide_d = col_d > MAX_COL;
		col_m1 = col_d - COL_W'(1);
		idx_d  = col_m1[AW-1:0];
		for (int p = 0; p < NPLANES; p++) begin
			if (wide_d) begin
				shift_d[p] = shift_q[p];
			end else begin
				shift_d[p] = {(start ? 7'd0 : shift_q[p][WIN-2:0]), pixel[PLANE_LO + p]};
			end
		end
	end

	// Counter and shift register state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			shift_q <= '0;
		end else if (accept) begin
			col_q   <= col_d;
			row_q   <= row_d;
			shift_q <= shift_d;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload. A same-column item ahead of this one writes the store
	// at this very edge, so its word is captured for forwarding.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1       <= idx_d;
			first_row_s1 <= row_d <= ROW_W'(1);
			too_wide_s1  <= wide_d;
			full_s1      <= !wide_d && col_d >= COL_W'(WIN) && row_d >= ROW_W'(WIN);
			shift_s1     <= shift_d;
			fwd_s1       <= valid_s1 && !too_wide_s1 && idx_s1 == idx_d;
			fwd_s1_word  <= store_s1;
		end
	end

	// Line store: one read at acceptance, one write as stage 1 retires unless over-wide.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[idx_d];
		end
		if (adv_s1 && !too_wide_s1) begin
			line_mem[idx_s1] <= store_s1;
		end
	end

	// Assemble the windows: upper rows shifted up one byte, new row in low byte.
	always_comb begin
		if (first_row_s1) begin
			upper_s1 = '0;
		end else if (fwd_s1) begin
			upper_s1 = fwd_s1_word;
		end else begin
			upper_s1 = rd_s1;
		end
		for (int p = 0; p < NPLANES; p++) begin
			word_s1[p]  = {upper_s1[p], shift_s1[p]};
			store_s1[p] = word_s1[p][STORE_W-1:0];
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; an over-wide pixel gives all-zero windows.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q      <= too_wide_s1 ? '0 : word_s1;
			full_q     <= full_s1;
			too_wide_q <= too_wide_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_bits4 = win_q[0];
	assign window_bits5 = win_q[1];
	assign window_bits6 = win_q[2];
	assign window_bits7 = win_q[3];
	assign window_full  = full_q;
	assign too_wide     = too_wide_q;

	`include "gradient_window_bit_packer_macros.svh"

	// An over-wide pixel carries no window content.
	`GWBP_ASSERT(a_wide_zero, out_valid_q && too_wide_q |-> win_q == '0 && !full_q)
	// Input is never held off while the output side can drain.
	`GWBP_ASSERT(a_no_bubble, (!out_valid_q || out_ready) |-> in_ready)
	// A row or frame start restarts the column count at one.
	`GWBP_ASSERT(a_col_restart, accept && start |=> col_q == COL_W'(1))
	// Once reset has been seen at an edge, nothing is offered at the next one.
	`GWBP_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q && !valid_s1)

endmodule
